@@ hdl/stlg_pkg.sv @@
package stlg_pkg;

    // Generator constants
    localparam logic signed [18:0] MOD_ONE   = 19'sd259100;
    localparam logic signed [18:0] MUL_ONE   = 19'sd7141;
    localparam logic signed [18:0] INC_ONE   = 19'sd54773;
    localparam logic signed [18:0] MOD_TWO   = 19'sd134456;
    localparam logic signed [18:0] MUL_TWO   = 19'sd8121;
    localparam logic signed [18:0] INC_TWO   = 19'sd28411;
    localparam logic signed [18:0] MOD_THREE = 19'sd243000;
    localparam logic signed [18:0] MUL_THREE = 19'sd4561;
    localparam logic signed [18:0] INC_THREE = 19'sd51349;

    // floor(2^32 / modulus): quotient estimate is exact or one low
    localparam logic signed [18:0] RCP_ONE   = 19'(64'd4294967296 / 64'd259100);
    localparam logic signed [18:0] RCP_TWO   = 19'(64'd4294967296 / 64'd134456);
    localparam logic signed [18:0] RCP_THREE = 19'(64'd4294967296 / 64'd243000);

    // Word widths
    localparam int OPERAND_W = 34;
    localparam int REM_W     = 20;
    localparam int QUO_W     = 16;
    localparam int MAJOR_W   = 20;
    localparam int MINOR_W   = 19;
    localparam int ENTRY_W   = MAJOR_W + MINOR_W;

    // Operations of the shared mul/mod unit
    typedef enum logic [2:0] {
        OP_SEED,
        OP_STEP1,
        OP_STEP2,
        OP_STEP3,
        OP_FOLD2,
        OP_FOLD3,
        OP_SLOT
    } mu_op_t;

    typedef enum logic [1:0] {
        MU_IDLE,
        MU_RECIP,
        MU_REDUCE
    } mu_phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED,
        ST_WARM1,
        ST_FOLD2,
        ST_WARM2,
        ST_FOLD3,
        ST_FILL1,
        ST_FILL2,
        ST_DRAW1,
        ST_DRAW2,
        ST_DRAW3,
        ST_SLOT,
        ST_READ,
        ST_WB
    } stlg_state_t;

    typedef struct packed {
        logic                          start;
        mu_op_t                        op;
        logic signed [OPERAND_W-1:0]   operand;
    } mu_req_t;

    typedef struct packed {
        logic                          done;
        logic                          neg;
        logic signed [REM_W-1:0]       rem;
        logic [QUO_W-1:0]              quo;
    } mu_rsp_t;

endpackage

@@ hdl/stlg_if.sv @@
interface stlg_seed_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] seed_word;

    modport source (output valid, output seed_word, input ready);
    modport sink (input valid, input seed_word, output ready);
endinterface

interface stlg_sample_if;
    logic               valid;
    logic               ready;
    logic signed [18:0] sample_major;
    logic signed [18:0] sample_minor;
    logic               seed_consumed;
    logic               slot_error;

    modport source (output valid, output sample_major, output sample_minor,
                    output seed_consumed, output slot_error, input ready);
    modport sink (input valid, input sample_major, input sample_minor,
                  input seed_consumed, input slot_error, output ready);
endinterface

@@ hdl/stlg_ram.sv @@
module stlg_ram #(
    parameter int WIDTH = 39,
    parameter int DEPTH = 97
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/stlg_mod_unit.sv @@
// Shared multiply / truncating-remainder unit.
// Start cycle: p = k*a + c.  Next: q ~= |p| * floor(2^32/m) >> 32.
// Last: r = |p| - q*m with one correction step; sign of p is applied.
module stlg_mod_unit #(
    parameter int TABLE_DEPTH = 97
) (
    input  logic             clk,
    input  logic             rst_n,
    input  stlg_pkg::mu_req_t req,
    output stlg_pkg::mu_rsp_t rsp
);

    stlg_pkg::mu_phase_t phase_reg, phase_next;
    stlg_pkg::mu_op_t    op_reg, op_cur;

    logic [31:0]                     x_reg, x_next;
    logic                            neg_reg, neg_next;
    logic [stlg_pkg::QUO_W-1:0]      q_reg, q_next;
    logic signed [stlg_pkg::REM_W-1:0] rem_reg, rem_next;
    logic [stlg_pkg::QUO_W-1:0]      quo_reg, quo_next;
    logic                            done_reg;

    logic signed [18:0] k_c, c_c, m_c, r_c;
    logic signed [stlg_pkg::OPERAND_W-1:0] mul_a;
    logic signed [18:0]                    mul_b;
    logic signed [52:0]                    prod, sum, p_abs;
    logic [32:0]                           diff, r_fix;
    logic                                  fix;

    assign op_cur = (phase_reg == stlg_pkg::MU_IDLE) ? req.op : op_reg;

    // Constant set for the operation
    always_comb
    begin
        case (op_cur)
            stlg_pkg::OP_SEED:
            begin
                k_c = -19'sd1;               c_c = stlg_pkg::INC_ONE;
                m_c = stlg_pkg::MOD_ONE;     r_c = stlg_pkg::RCP_ONE;
            end
            stlg_pkg::OP_STEP1:
            begin
                k_c = stlg_pkg::MUL_ONE;     c_c = stlg_pkg::INC_ONE;
                m_c = stlg_pkg::MOD_ONE;     r_c = stlg_pkg::RCP_ONE;
            end
            stlg_pkg::OP_STEP2:
            begin
                k_c = stlg_pkg::MUL_TWO;     c_c = stlg_pkg::INC_TWO;
                m_c = stlg_pkg::MOD_TWO;     r_c = stlg_pkg::RCP_TWO;
            end
            stlg_pkg::OP_STEP3:
            begin
                k_c = stlg_pkg::MUL_THREE;   c_c = stlg_pkg::INC_THREE;
                m_c = stlg_pkg::MOD_THREE;   r_c = stlg_pkg::RCP_THREE;
            end
            stlg_pkg::OP_FOLD2:
            begin
                k_c = 19'sd1;                c_c = 19'sd0;
                m_c = stlg_pkg::MOD_TWO;     r_c = stlg_pkg::RCP_TWO;
            end
            stlg_pkg::OP_FOLD3:
            begin
                k_c = 19'sd1;                c_c = 19'sd0;
                m_c = stlg_pkg::MOD_THREE;   r_c = stlg_pkg::RCP_THREE;
            end
            stlg_pkg::OP_SLOT:
            begin
                k_c = 19'(TABLE_DEPTH);      c_c = 19'sd0;
                m_c = stlg_pkg::MOD_THREE;   r_c = stlg_pkg::RCP_THREE;
            end
            default:
            begin
                k_c = stlg_pkg::MUL_ONE;     c_c = stlg_pkg::INC_ONE;
                m_c = stlg_pkg::MOD_ONE;     r_c = stlg_pkg::RCP_ONE;
            end
        endcase
    end

    // Phase sequencing
    always_comb
    begin
        case (phase_reg)
            stlg_pkg::MU_IDLE:   phase_next = req.start ? stlg_pkg::MU_RECIP : stlg_pkg::MU_IDLE;
            stlg_pkg::MU_RECIP:  phase_next = stlg_pkg::MU_REDUCE;
            stlg_pkg::MU_REDUCE: phase_next = stlg_pkg::MU_IDLE;
            default:             phase_next = stlg_pkg::MU_IDLE;
        endcase
    end

    // Operand select for the one multiplier
    always_comb
    begin
        case (phase_reg)
            stlg_pkg::MU_RECIP:
            begin
                mul_a = {2'b00, x_reg};
                mul_b = r_c;
            end
            stlg_pkg::MU_REDUCE:
            begin
                mul_a = {{(stlg_pkg::OPERAND_W - stlg_pkg::QUO_W){1'b0}}, q_reg};
                mul_b = m_c;
            end
            default:
            begin
                mul_a = req.operand;
                mul_b = k_c;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // Datapath next values
    always_comb
    begin
        sum      = prod + 53'(c_c);
        p_abs    = sum[52] ? -sum : sum;
        x_next   = p_abs[31:0];
        neg_next = sum[52];
        q_next   = prod[47:32];
        diff     = {1'b0, x_reg} - prod[32:0];
        fix      = diff >= {14'b0, m_c};
        r_fix    = fix ? diff - {14'b0, m_c} : diff;
        quo_next = q_reg + stlg_pkg::QUO_W'(fix);
        rem_next = neg_reg ? (20'sd0 - $signed(r_fix[19:0])) : $signed(r_fix[19:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= stlg_pkg::MU_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= (phase_reg == stlg_pkg::MU_REDUCE);
        end
    end

    always_ff @(posedge clk)
    begin
        case (phase_reg)
            stlg_pkg::MU_IDLE:
            begin
                if (req.start)
                begin
                    op_reg  <= req.op;
                    x_reg   <= x_next;
                    neg_reg <= neg_next;
                end
            end
            stlg_pkg::MU_RECIP:
            begin
                q_reg <= q_next;
            end
            stlg_pkg::MU_REDUCE:
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
            end
            default:
            begin
            end
        endcase
    end

    assign rsp.done = done_reg;
    assign rsp.neg  = neg_reg;
    assign rsp.rem  = rem_reg;
    assign rsp.quo  = quo_reg;

endmodule

@@ hdl/shuffled_triple_lcg_generator_core.sv @@
// Each mul/mod operation runs on the shared multiplier unit.
// Draw without reseed: 4 operations plus table read and write-back; a new request
// is accepted only once the result has been loaded into the output register.
// Reseed adds 5 + 2*TABLE_DEPTH operations.
// Reset clears the generators and the seeded flag; the first request always reseeds.
// The shuffle table has no reset; every entry is written by the reseed fill.
module shuffled_triple_lcg_generator_core #(
    parameter int TABLE_DEPTH = 97
) (
    input  logic          clk,
    input  logic          rst_n,
    stlg_seed_if.sink     seed_ch,
    stlg_sample_if.source sample_ch
);

    localparam int IDXW = $clog2(TABLE_DEPTH);

    stlg_pkg::stlg_state_t state_reg, state_next;
    stlg_pkg::mu_req_t     mu_req;
    stlg_pkg::mu_rsp_t     mu_rsp;

    logic                          issued_reg, issued_next;
    logic                          op_state;
    logic signed [31:0]            seed_reg, seed_next;
    logic                          reseed_reg, reseed_next;
    logic                          seeded_reg, seeded_next;
    logic signed [19:0]            g1_reg, g1_next;
    logic signed [18:0]            g2_reg, g2_next;
    logic signed [18:0]            g3_reg, g3_next;
    logic [IDXW-1:0]               fill_reg, fill_next;
    logic [IDXW-1:0]               slot_reg, slot_next;
    logic                          err_reg, err_next;
    logic                          fill_last;
    logic                          seed_take;
    logic                          load_out;

    logic                          out_valid_reg, out_valid_next;
    logic signed [18:0]            out_major_reg, out_minor_reg;
    logic                          out_consumed_reg, out_err_reg;

    logic                          ram_we, ram_re;
    logic [IDXW-1:0]               ram_waddr;
    logic [stlg_pkg::ENTRY_W-1:0]  ram_wdata, ram_rdata;

    stlg_mod_unit #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mu_req),
        .rsp   (mu_rsp)
    );

    stlg_ram #(
        .WIDTH (stlg_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    assign seed_take = seed_ch.valid && seed_ch.ready;
    assign fill_last = (fill_reg == IDXW'(TABLE_DEPTH - 1));
    assign load_out  = (state_reg == stlg_pkg::ST_WB) && (!out_valid_reg || sample_ch.ready);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            stlg_pkg::ST_IDLE:
            begin
                if (seed_take)
                begin
                    state_next = (seed_ch.seed_word[31] || !seeded_reg) ?
                                 stlg_pkg::ST_SEED : stlg_pkg::ST_DRAW1;
                end
            end
            stlg_pkg::ST_SEED:  if (mu_rsp.done) state_next = stlg_pkg::ST_WARM1;
            stlg_pkg::ST_WARM1: if (mu_rsp.done) state_next = stlg_pkg::ST_FOLD2;
            stlg_pkg::ST_FOLD2: if (mu_rsp.done) state_next = stlg_pkg::ST_WARM2;
            stlg_pkg::ST_WARM2: if (mu_rsp.done) state_next = stlg_pkg::ST_FOLD3;
            stlg_pkg::ST_FOLD3: if (mu_rsp.done) state_next = stlg_pkg::ST_FILL1;
            stlg_pkg::ST_FILL1: if (mu_rsp.done) state_next = stlg_pkg::ST_FILL2;
            stlg_pkg::ST_FILL2:
            begin
                if (mu_rsp.done)
                begin
                    state_next = fill_last ? stlg_pkg::ST_DRAW1 : stlg_pkg::ST_FILL1;
                end
            end
            stlg_pkg::ST_DRAW1: if (mu_rsp.done) state_next = stlg_pkg::ST_DRAW2;
            stlg_pkg::ST_DRAW2: if (mu_rsp.done) state_next = stlg_pkg::ST_DRAW3;
            stlg_pkg::ST_DRAW3: if (mu_rsp.done) state_next = stlg_pkg::ST_SLOT;
            stlg_pkg::ST_SLOT:  if (mu_rsp.done) state_next = stlg_pkg::ST_READ;
            stlg_pkg::ST_READ:  state_next = stlg_pkg::ST_WB;
            stlg_pkg::ST_WB:    if (load_out) state_next = stlg_pkg::ST_IDLE;
            default:            state_next = stlg_pkg::ST_IDLE;
        endcase
    end

    // Control outputs: handshake, unit request, table access
    always_comb
    begin
        seed_ch.ready  = (state_reg == stlg_pkg::ST_IDLE);
        op_state       = 1'b1;
        mu_req.op      = stlg_pkg::OP_STEP1;
        mu_req.operand = {{14{g1_reg[19]}}, g1_reg};
        case (state_reg)
            stlg_pkg::ST_SEED:
            begin
                mu_req.op      = stlg_pkg::OP_SEED;
                mu_req.operand = {{2{seed_reg[31]}}, seed_reg};
            end
            stlg_pkg::ST_WARM1, stlg_pkg::ST_WARM2,
            stlg_pkg::ST_FILL1, stlg_pkg::ST_DRAW1:
            begin
                mu_req.op = stlg_pkg::OP_STEP1;
            end
            stlg_pkg::ST_FOLD2:
            begin
                mu_req.op = stlg_pkg::OP_FOLD2;
            end
            stlg_pkg::ST_FOLD3:
            begin
                mu_req.op = stlg_pkg::OP_FOLD3;
            end
            stlg_pkg::ST_FILL2, stlg_pkg::ST_DRAW2:
            begin
                mu_req.op      = stlg_pkg::OP_STEP2;
                mu_req.operand = {{15{g2_reg[18]}}, g2_reg};
            end
            stlg_pkg::ST_DRAW3:
            begin
                mu_req.op      = stlg_pkg::OP_STEP3;
                mu_req.operand = {{15{g3_reg[18]}}, g3_reg};
            end
            stlg_pkg::ST_SLOT:
            begin
                mu_req.op      = stlg_pkg::OP_SLOT;
                mu_req.operand = {{15{g3_reg[18]}}, g3_reg};
            end
            default:
            begin
                op_state = 1'b0;
            end
        endcase
        mu_req.start = op_state && !issued_reg;

        ram_re = (state_reg == stlg_pkg::ST_READ) && !err_reg;
        if (state_reg == stlg_pkg::ST_FILL2)
        begin
            ram_we    = mu_rsp.done;
            ram_waddr = fill_reg;
            ram_wdata = {g1_reg, mu_rsp.rem[18:0]};
        end
        else
        begin
            ram_we    = load_out && !err_reg;
            ram_waddr = slot_reg;
            ram_wdata = {g1_reg, g2_reg};
        end
    end

    // Datapath next values
    always_comb
    begin
        issued_next    = mu_req.start ? 1'b1 : (mu_rsp.done ? 1'b0 : issued_reg);
        seed_next      = seed_reg;
        reseed_next    = reseed_reg;
        seeded_next    = seeded_reg;
        g1_next        = g1_reg;
        g2_next        = g2_reg;
        g3_next        = g3_reg;
        fill_next      = fill_reg;
        slot_next      = slot_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg;

        if (seed_take)
        begin
            seed_next   = seed_ch.seed_word;
            reseed_next = seed_ch.seed_word[31] || !seeded_reg;
            fill_next   = '0;
        end

        if (mu_rsp.done)
        begin
            case (state_reg)
                stlg_pkg::ST_SEED, stlg_pkg::ST_WARM1, stlg_pkg::ST_WARM2,
                stlg_pkg::ST_FILL1, stlg_pkg::ST_DRAW1:
                begin
                    g1_next = mu_rsp.rem;
                end
                stlg_pkg::ST_FOLD2, stlg_pkg::ST_DRAW2:
                begin
                    g2_next = mu_rsp.rem[18:0];
                end
                stlg_pkg::ST_FILL2:
                begin
                    g2_next = mu_rsp.rem[18:0];
                    if (fill_last)
                    begin
                        seeded_next = 1'b1;
                    end
                    else
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                end
                stlg_pkg::ST_FOLD3, stlg_pkg::ST_DRAW3:
                begin
                    g3_next = mu_rsp.rem[18:0];
                end
                stlg_pkg::ST_SLOT:
                begin
                    // negative nonzero quotient, or one above TABLE_DEPTH - 1, is an invalid slot
                    slot_next = mu_rsp.quo[IDXW-1:0];
                    err_next  = (mu_rsp.neg && (mu_rsp.quo != '0)) ||
                                (mu_rsp.quo > stlg_pkg::QUO_W'(TABLE_DEPTH - 1));
                end
                default:
                begin
                end
            endcase
        end

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (sample_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stlg_pkg::ST_IDLE;
            issued_reg    <= 1'b0;
            seeded_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            g1_reg        <= '0;
            g2_reg        <= '0;
            g3_reg        <= '0;
            fill_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            seeded_reg    <= seeded_next;
            out_valid_reg <= out_valid_next;
            g1_reg        <= g1_next;
            g2_reg        <= g2_next;
            g3_reg        <= g3_next;
            fill_reg      <= fill_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        seed_reg   <= seed_next;
        reseed_reg <= reseed_next;
        slot_reg   <= slot_next;
        err_reg    <= err_next;
        if (load_out)
        begin
            out_major_reg    <= err_reg ? 19'sd0 : ram_rdata[37:19];
            out_minor_reg    <= err_reg ? 19'sd0 : ram_rdata[18:0];
            out_consumed_reg <= reseed_reg;
            out_err_reg      <= err_reg;
        end
    end

    assign sample_ch.valid         = out_valid_reg;
    assign sample_ch.sample_major  = out_major_reg;
    assign sample_ch.sample_minor  = out_minor_reg;
    assign sample_ch.seed_consumed = out_consumed_reg;
    assign sample_ch.slot_error    = out_err_reg;

    // Checks
    assert property (@(posedge clk) disable iff (!rst_n)
        mu_rsp.done |-> issued_reg)
        else $error("mod unit finished with no operation outstanding");

    assert property (@(posedge clk) disable iff (!rst_n)
        seeded_reg |=> seeded_reg)
        else $error("seeded flag dropped");

    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (32'(ram_waddr) < TABLE_DEPTH))
        else $error("table write outside depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (sample_ch.valid && sample_ch.slot_error) |->
        (sample_ch.sample_major == 19'sd0 && sample_ch.sample_minor == 19'sd0))
        else $error("slot error result carries nonzero sample");

endmodule
